>>> src/masked_row_softmax_core_defines.svh
// Assertion macros for the masked row softmax core
`ifndef MASKED_ROW_SOFTMAX_CORE_DEFINES_SVH
`define MASKED_ROW_SOFTMAX_CORE_DEFINES_SVH
`define MRS_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define MRS_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

>>> src/mrs_pkg.sv
//------------------------------------------------------------------------------
// mrs_pkg
// Shared types, constants and exponent table for the masked row softmax core.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package mrs_pkg;
  localparam int MAX_ROW_DEF = 64;
  localparam int QDEPTH = 2;

  typedef struct packed {
    logic       first;
    logic       store;
    logic       last;
    logic [5:0] idx;
    logic [15:0] logit;
    logic [6:0] vlen;
  } mrs_req_t;

  function automatic logic [16:0] pow2_tab(input logic [4:0] j);
    logic [16:0] v;
    case (j)
      5'd0: v = 17'd65536;  5'd1: v = 17'd62757;  5'd2: v = 17'd60097;
      5'd3: v = 17'd57549;  5'd4: v = 17'd55109;  5'd5: v = 17'd52773;
      5'd6: v = 17'd50535;  5'd7: v = 17'd48393;  5'd8: v = 17'd46341;
      5'd9: v = 17'd44376;  5'd10: v = 17'd42495; 5'd11: v = 17'd40693;
      5'd12: v = 17'd38968; 5'd13: v = 17'd37316; 5'd14: v = 17'd35734;
      5'd15: v = 17'd34219; default: v = 17'd32768;
    endcase
    return v;
  endfunction
endpackage

>>> src/mrs_front.sv
//------------------------------------------------------------------------------
// mrs_front
// Accepts logits, samples the valid length and tags each request for the back.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module mrs_front #(
  parameter int MAX_ROW = mrs_pkg::MAX_ROW_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [15:0]       in_logit,
  input  logic [6:0]        in_valid_count,
  input  logic              in_last_in_row,
  output mrs_pkg::mrs_req_t req
);
  import mrs_pkg::*;
  localparam logic [6:0] MAXR = 7'(MAX_ROW);
  logic [6:0] cnt_r, vlen_r;
  logic [6:0] vl, idx;

  assign idx = cnt_r;
  assign vl  = (cnt_r == 7'd0) ? ((in_valid_count > MAXR) ? MAXR : in_valid_count) : vlen_r;
  always_comb begin
    req.first = (cnt_r == 7'd0);
    req.store = (idx < MAXR) && (idx < vl);
    req.last  = in_last_in_row;
    req.idx   = idx[5:0];
    req.logit = in_logit;
    req.vlen  = vl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      vlen_r <= '0;
    end else if (acc) begin
      vlen_r <= vl;
      if (in_last_in_row) cnt_r <= '0;
      else if (cnt_r < MAXR) cnt_r <= cnt_r + 7'd1;
    end
  end
endmodule

>>> src/mrs_queue.sv
//------------------------------------------------------------------------------
// mrs_queue
// Short request FIFO between front and back.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module mrs_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mrs_pkg::mrs_req_t din,
  input  logic              pop,
  output mrs_pkg::mrs_req_t dout,
  output logic              empty,
  output logic              full
);
  import mrs_pkg::*;
  mrs_req_t mem_r [QDEPTH];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'(QDEPTH));
  assign dout  = mem_r[rp_r];
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

>>> src/mrs_back.sv
//------------------------------------------------------------------------------
// mrs_back
// Stores logits, then runs exponent, reciprocal and normalise passes.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module mrs_back #(
  parameter int MAX_ROW = mrs_pkg::MAX_ROW_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  mrs_pkg::mrs_req_t q_req,
  output logic              q_pop,
  output logic              idle,
  output logic              out_strobe,
  output logic [15:0]       out_prob,
  output logic [5:0]        out_position,
  output logic              out_last_of_run
);
  import mrs_pkg::*;
  localparam logic [3:0] S_LOAD = 4'd0, S_ERD = 4'd1, S_EMUL = 4'd2, S_EINT = 4'd3,
    S_ESH = 4'd4, S_DIV = 4'd5, S_NRD = 4'd6, S_NMUL = 4'd7, S_NOUT = 4'd8;

  logic [3:0]  st_r;
  logic [15:0] lmem [MAX_ROW];
  logic [15:0] emem [MAX_ROW];
  logic [15:0] lrd_r, erd_r;
  logic [6:0]  n_r, k_r;
  logic signed [15:0] max_r;
  logic [22:0] sum_r;
  logic [33:0] u_r;
  logic [16:0] v_r;
  logic [32:0] rem_r;
  logic [32:0] quo_r;
  logic [5:0]  dc_r;
  logic [32:0] recip_r;
  logic [48:0] p_r;
  logic [5:0]  kidx;
  logic [16:0] t;
  logic [4:0]  j;
  logic [19:0] rf;
  logic [16:0] pa, pb, diff;
  logic [36:0] dm;
  logic [16:0] vq;
  logic [9:0]  ip;
  logic [17:0] rsh;
  logic [16:0] ev;
  logic [15:0] es;
  logic [22:0] sum_nxt;
  logic [33:0] rsub;
  logic [48:0] pr;

  assign kidx  = k_r[5:0];
  assign idle  = (st_r == S_LOAD) && q_empty;
  assign q_pop = (st_r == S_LOAD) && !q_empty;

  assign t    = 17'($signed({max_r[15], max_r}) - $signed({lrd_r[15], lrd_r}));
  assign j    = {1'b0, u_r[23:20]};
  assign rf   = u_r[19:0];
  assign pa   = pow2_tab(j);
  assign pb   = pow2_tab(j + 5'd1);
  assign diff = pa - pb;
  assign dm   = 37'(diff) * 37'(rf) + 37'd524288;
  assign vq   = pa - 17'(dm >> 20);
  assign ip   = u_r[33:24];
  assign rsh  = (18'(v_r) + ((ip == 10'd0) ? 18'd0 : (18'd1 << (ip - 10'd1)))) >> ip;
  assign ev   = (ip >= 10'd17) ? 17'd0 : 17'(rsh);
  assign es   = (ev > 17'd65535) ? 16'hFFFF : ev[15:0];
  assign sum_nxt = sum_r + 23'(es);
  assign rsub = {rem_r, quo_r[32]} - 34'(sum_r);
  assign pr   = p_r + 49'd32768;

  always_ff @(posedge clk) begin
    if (q_pop && q_req.store) lmem[q_req.idx] <= q_req.logit;
    lrd_r <= lmem[kidx];
    if (st_r == S_ESH) emem[kidx] <= es;
    erd_r <= emem[kidx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD; max_r <= 16'sh8000; sum_r <= '0; n_r <= '0; k_r <= '0;
      out_strobe <= 1'b0; out_last_of_run <= 1'b0;
    end else begin
      out_strobe <= 1'b0;
      unique case (st_r)
        S_LOAD: if (q_pop) begin
          if (q_req.first) max_r <= 16'sh8000;
          if (q_req.store && (q_req.first || $signed(q_req.logit) > max_r))
            max_r <= q_req.logit;
          if (q_req.store) n_r <= 7'(q_req.idx) + 7'd1;
          else if (q_req.first) n_r <= '0;
          if (q_req.last) begin
            k_r <= '0; sum_r <= '0;
            if ((q_req.store ? 7'(q_req.idx) + 7'd1 : (q_req.first ? 7'd0 : n_r)) != 7'd0)
              st_r <= S_ERD;
          end
        end
        S_ERD:  st_r <= S_EMUL;
        S_EMUL: begin u_r <= 34'(t) * 34'd94548; st_r <= S_EINT; end
        S_EINT: begin v_r <= vq; st_r <= S_ESH; end
        S_ESH: begin
          sum_r <= sum_nxt;
          if (k_r + 7'd1 == n_r) begin
            st_r  <= S_DIV; dc_r <= 6'd32;
            rem_r <= '0; quo_r <= {1'b1, 10'd0, sum_nxt[22:1]};
          end else begin
            k_r <= k_r + 7'd1; st_r <= S_ERD;
          end
        end
        S_DIV: begin
          if (!rsub[33]) begin rem_r <= rsub[32:0]; quo_r <= {quo_r[31:0], 1'b1}; end
          else begin rem_r <= {rem_r[31:0], quo_r[32]}; quo_r <= {quo_r[31:0], 1'b0}; end
          dc_r <= dc_r - 6'd1;
          if (dc_r == 6'd0) begin
            st_r <= S_NRD; k_r <= '0;
            recip_r <= rsub[33] ? {quo_r[31:0], 1'b0} : {quo_r[31:0], 1'b1};
          end
        end
        S_NRD:  st_r <= S_NMUL;
        S_NMUL: begin p_r <= 49'(erd_r) * 49'(recip_r); st_r <= S_NOUT; end
        S_NOUT: begin
          out_strobe      <= 1'b1;
          out_prob        <= (pr[48:32] != 17'd0) ? 16'hFFFF : pr[31:16];
          out_position    <= kidx;
          out_last_of_run <= (k_r + 7'd1 == n_r);
          if (k_r + 7'd1 == n_r) begin
            st_r <= S_LOAD; max_r <= 16'sh8000; n_r <= '0;
          end else begin
            k_r <= k_r + 7'd1; st_r <= S_NRD;
          end
        end
        default: st_r <= S_LOAD;
      endcase
    end
  end
endmodule

>>> src/masked_row_softmax_core.sv
//------------------------------------------------------------------------------
// masked_row_softmax_core
// Softmax over the leading valid elements of a row of Q8.8 logits.
//------------------------------------------------------------------------------
// Requests are taken one per cycle while busy is low and a row is loading.
// After the last request the back end runs the exponent pass, the serial
// reciprocal and the normalise pass; busy stays high meanwhile. Each
// probability appears for one cycle with out_strobe and must be taken
// then.
`timescale 1ns / 1ps
`include "masked_row_softmax_core_defines.svh"
module masked_row_softmax_core #(
  parameter int MAX_ROW = mrs_pkg::MAX_ROW_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_logit,
  input  logic [6:0]  in_valid_count,
  input  logic        in_last_in_row,
  output logic        out_strobe,
  output logic [15:0] out_prob,
  output logic [5:0]  out_position,
  output logic        out_last_of_run
);
  import mrs_pkg::*;
  mrs_req_t req, qreq;
  logic acc, pop, empty, full, idle, hold_r;

  assign acc  = start && !busy;
  assign busy = full || hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) hold_r <= 1'b0;
    else if (acc && in_last_in_row) hold_r <= 1'b1;
    else if (idle && !acc) hold_r <= 1'b0;
  end

  mrs_front #(.MAX_ROW(MAX_ROW)) u_front (.clk, .rst_n, .acc, .in_logit,
    .in_valid_count, .in_last_in_row, .req);
  mrs_queue u_queue (.clk, .rst_n, .push(acc), .din(req), .pop, .dout(qreq),
    .empty, .full);
  mrs_back #(.MAX_ROW(MAX_ROW)) u_back (.clk, .rst_n, .q_empty(empty), .q_req(qreq),
    .q_pop(pop), .idle, .out_strobe, .out_prob, .out_position, .out_last_of_run);

  `MRS_ASSERT_IMP(a_no_push_full, clk, rst_n, full, !acc, "request taken while queue full")
  `MRS_ASSERT_NXT(a_hold_last, clk, rst_n, acc && in_last_in_row, busy, "not busy after row end")
  `MRS_ASSERT_IMP(a_no_out_idle, clk, rst_n, out_strobe, hold_r, "result outside row processing")
endmodule

>>> sim/masked_row_softmax_core_test.sv
//------------------------------------------------------------------------------
// masked_row_softmax_core_test
// Self-checking bench for the masked row softmax core: rows of logits are
// sent as requests with random gaps, a local fixed-point softmax predicts
// every probability, and each strobed result is checked against it in order.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module masked_row_softmax_core_test;

  localparam int ROW_CAP   = 64;
  localparam int CYCLE_CAP = 400000;

  typedef struct {
    logic [15:0] logit;
    logic [6:0]  valid_count;
    logic        last_in_row;
  } logit_req_t;

  typedef struct {
    logic [15:0] prob;
    logic [5:0]  position;
    logic        last_of_run;
  } prob_res_t;

  localparam longint unsigned EXP2_FRAC [17] = '{
    65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
    46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768
  };

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [15:0] in_logit;
  logic [6:0]  in_valid_count;
  logic        in_last_in_row;
  logic        out_strobe;
  logic [15:0] out_prob;
  logic [5:0]  out_position;
  logic        out_last_of_run;

  logit_req_t  req_queue[$];
  prob_res_t   prob_queue[$];
  int          fail_count = 0;
  int          sent_count = 0;
  longint      cycle_count = 0;

  logic signed [15:0] row_logits [ROW_CAP];
  int                 row_seen = 0;
  int                 row_len = 0;
  logic signed [15:0] row_max = -16'sd32768;

  masked_row_softmax_core DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_logit(in_logit), .in_valid_count(in_valid_count),
    .in_last_in_row(in_last_in_row), .out_strobe(out_strobe),
    .out_prob(out_prob), .out_position(out_position),
    .out_last_of_run(out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint unsigned exp_neg(input longint unsigned t);
    longint unsigned u, ip, fr, j, r, diff, v, e;
    u = t * 94548;
    ip = u >> 24;
    fr = u & 64'hFFFFFF;
    j = fr >> 20;
    r = fr & 64'hFFFFF;
    diff = EXP2_FRAC[j] - EXP2_FRAC[j + 1];
    v = EXP2_FRAC[j] - ((diff * r + (64'd1 << 19)) >> 20);
    if (ip >= 17) e = 0;
    else if (ip == 0) e = v;
    else e = (v + (64'd1 << (ip - 1))) >> ip;
    return (e > 65535) ? 65535 : e;
  endfunction

  task automatic predict_softmax(input logit_req_t r);
    int n;
    longint unsigned sum, recip, p;
    longint unsigned ex [ROW_CAP];
    prob_res_t res;
    if (row_seen == 0) row_len = (r.valid_count > ROW_CAP) ? ROW_CAP : r.valid_count;
    if (row_seen < ROW_CAP) begin
      if (row_seen < row_len) begin
        row_logits[row_seen] = r.logit;
        if ($signed(r.logit) > row_max) row_max = r.logit;
      end
      row_seen++;
    end
    if (!r.last_in_row) return;
    n = (row_len < row_seen) ? row_len : row_seen;
    sum = 0;
    for (int k = 0; k < n; k++) begin
      ex[k] = exp_neg(longint'(int'(row_max) - int'(row_logits[k])));
      sum = (sum + ex[k]) & 64'h7FFFFF;
    end
    if (n > 0) begin
      recip = ((64'd1 << 32) + (sum >> 1)) / sum;
      for (int k = 0; k < n; k++) begin
        p = (ex[k] * recip + 32768) >> 16;
        res.prob = (p > 65535) ? 16'hFFFF : p[15:0];
        res.position = k[5:0];
        res.last_of_run = (k + 1 == n);
        prob_queue.push_back(res);
      end
    end
    row_seen = 0;
    row_len = 0;
    row_max = -16'sd32768;
  endtask

  task automatic add_row(input int len, input int vc, input int base, input int spread);
    logit_req_t r;
    int x;
    for (int i = 0; i < len; i++) begin
      x = base + $signed($urandom_range(0, 2 * spread)) - spread;
      if (x > 32767) x = 32767;
      if (x < -32768) x = -32768;
      r.logit = x[15:0];
      r.valid_count = (i == 0) ? vc[6:0] : 7'($urandom_range(0, 127));
      r.last_in_row = (i == len - 1);
      req_queue.push_back(r);
    end
  endtask

  task automatic add_item(input int x, input int vc, input bit last);
    logit_req_t r;
    r.logit = x[15:0];
    r.valid_count = vc[6:0];
    r.last_in_row = last;
    req_queue.push_back(r);
  endtask

  always @(posedge clk) begin
    logit_req_t nxt;
    bit go;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_softmax(req_queue.pop_front());
        sent_count++;
      end
      if (!(start && busy)) begin
        go = (req_queue.size() > 0) &&
             ((sent_count >= 90 && sent_count < 150) || $urandom_range(0, 99) >= 31);
        if (go) begin
          nxt = req_queue[0];
          in_logit <= nxt.logit;
          in_valid_count <= nxt.valid_count;
          in_last_in_row <= nxt.last_in_row;
        end
        start <= go;
      end
    end
  end

  always @(posedge clk) begin
    prob_res_t exp_res;
    if (rst_n && out_strobe) begin
      if (prob_queue.size() == 0) begin
        $error("unexpected result prob=%0d position=%0d", out_prob, out_position);
        fail_count++;
      end else begin
        exp_res = prob_queue.pop_front();
        if (out_prob !== exp_res.prob) begin
          $error("prob expected %0d actual %0d", exp_res.prob, out_prob);
          fail_count++;
        end
        if (out_position !== exp_res.position) begin
          $error("position expected %0d actual %0d", exp_res.position, out_position);
          fail_count++;
        end
        if (out_last_of_run !== exp_res.last_of_run) begin
          $error("last_of_run expected %0d actual %0d", exp_res.last_of_run,
                 out_last_of_run);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int len, vc;
    rst_n = 1'b0;
    start = 1'b0;
    in_logit = '0;
    in_valid_count = '0;
    in_last_in_row = 1'b0;

    add_item(32767, 1, 1'b1);
    add_item(-32768, 1, 1'b1);
    add_item(100, 0, 1'b0);
    add_item(200, 0, 1'b1);
    add_item(32767, 3, 1'b0);
    add_item(-32768, 0, 1'b0);
    add_item(0, 0, 1'b1);
    add_item(256, 127, 1'b0);
    add_item(-256, 5, 1'b0);
    add_item(512, 0, 1'b1);
    add_item(10, 2, 1'b0);
    add_item(-10, 64, 1'b0);
    add_item(30000, 1, 1'b0);
    add_item(-30000, 0, 1'b1);
    add_item(-1, 4, 1'b0);
    add_item(-1, 0, 1'b0);
    add_item(-1, 0, 1'b0);
    add_item(-1, 0, 1'b1);
    add_item(0, 65, 1'b1);

    while (req_queue.size() < 100) begin
      len = $urandom_range(1, 8);
      case ($urandom_range(0, 9))
        0: vc = 0;
        1: vc = $urandom_range(0, 127);
        2: vc = $urandom_range(0, len);
        default: vc = len;
      endcase
      if ($urandom_range(0, 3) == 0)
        add_row(len, vc, 0, 32767);
      else
        add_row(len, vc, $signed($urandom_range(0, 60000)) - 30000, $urandom_range(0, 2000));
    end
    add_row(68, 64, 0, 1500);
    add_row(40, 127, -2000, 800);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (req_queue.size() != 0 || start || busy || prob_queue.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && prob_queue.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

>>> masked_row_softmax_core.f
+incdir+src
src/mrs_pkg.sv
src/mrs_front.sv
src/mrs_queue.sv
src/mrs_back.sv
src/masked_row_softmax_core.sv
sim/masked_row_softmax_core_test.sv
